// ===== design/pcg32_random_generator_unit_macros.svh =====
// assertion macros shared by the pcg32 generator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef PCG32_RANDOM_GENERATOR_UNIT_MACROS_SVH
`define PCG32_RANDOM_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PCG32_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcg32 same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PCG32_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcg32 next-cycle check failed");

`endif

// ===== design/pcg32_pkg.sv =====
// shared types, constants and the xsh-rr output function for the pcg32 generator
// no dependencies; imported by every pcg32 module
package pcg32_pkg;

  // lcg multiplier and its 32-bit halves
  localparam logic [63:0] PCG_MULT    = 64'h5851_F42D_4C95_7F2D;
  localparam logic [31:0] PCG_MULT_LO = PCG_MULT[31:0];
  localparam logic [31:0] PCG_MULT_HI = PCG_MULT[63:32];

  localparam int XS_SHIFT   = 18;
  localparam int XS_DROP    = 27;
  localparam int ROT_POS    = 59;
  localparam int FRAC_SHIFT = 8;

  // configuration register indexes
  localparam logic CFG_SEED   = 1'b0;
  localparam logic CFG_STREAM = 1'b1;

  typedef enum logic [1:0] {
    KIND_RESEED  = 2'd0,
    KIND_RAW     = 2'd1,
    KIND_BOUNDED = 2'd2,
    KIND_FRAC    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] bound;
  } in_t;

  typedef struct packed {
    logic [31:0] value;
    logic        bad_bound;
  } out_t;

  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_DRAW,
    VAL_FRAC,
    VAL_REM
  } val_sel_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LO_LO,
    MUL_LO_HI,
    MUL_HI_LO
  } mul_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RS_LOAD,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_RS_SEED,
    S_THR,
    S_THR_WAIT,
    S_MOD,
    S_MOD_WAIT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic     load_item;
    logic     rs_load;
    mul_op_e  mul_op;
    logic     add_inc;
    logic     add_seed;
    logic     div_start;
    logic     div_sel_draw;
    logic     thr_load;
    logic     emit;
    val_sel_e emit_sel;
    logic     emit_bad;
  } cmd_t;

  typedef struct packed {
    logic bound_zero;
    logic draw_ok;
    logic div_done;
  } sts_t;

  // xsh-rr permutation of the pre-step state
  function automatic logic [31:0] pcg32_output(input logic [63:0] s);
    logic [63:0] x;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] dbl;
    x   = (s >> XS_SHIFT) ^ s;
    xs  = x[XS_DROP +: 32];
    rot = s[ROT_POS +: 5];
    dbl = {xs, xs} >> rot;
    return dbl[31:0];
  endfunction

endpackage

// ===== design/pcg32_divider.sv =====
// iterative restoring remainder unit, one quotient bit per cycle
// depends on pcg32_pkg
module pcg32_divider
  import pcg32_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvd_q, dvd_d;
  logic [32:0] trial;

  assign trial = {rem_q, dvd_q[31]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = 32'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[31:0];
      end
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/pcg32_datapath.sv =====
// lcg state, shared 32x32 multiplier, threshold and output registers
// depends on pcg32_pkg and pcg32_divider
module pcg32_datapath
  import pcg32_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [31:0] bound_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output out_t        out_o
);

  logic [63:0] state_q, state_d;
  logic [63:0] inc_q, inc_d;
  logic [63:0] seed_q, seed_d;
  logic [62:0] stream_q, stream_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] draw_q, draw_d;
  logic [31:0] bound_q, bound_d;
  logic [31:0] thr_q, thr_d;
  out_t        out_q, out_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] div_dividend;
  logic [31:0] div_rem;
  logic        div_done;

  pcg32_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (bound_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // threshold phase divides (2^32 - bound) at 32 bits
  assign div_dividend = cmd_i.div_sel_draw ? draw_q : 32'(32'd0 - bound_q);

  always_comb begin
    case (cmd_i.mul_op)
      MUL_LO_HI: begin
        mul_a = state_q[31:0];
        mul_b = PCG_MULT_HI;
      end
      MUL_HI_LO: begin
        mul_a = state_q[63:32];
        mul_b = PCG_MULT_LO;
      end
      default: begin
        mul_a = state_q[31:0];
        mul_b = PCG_MULT_LO;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    acc_d  = acc_q;
    draw_d = draw_q;
    case (cmd_i.mul_op)
      MUL_LO_LO: begin
        acc_d  = prod;
        draw_d = pcg32_output(state_q);
      end
      MUL_LO_HI, MUL_HI_LO: begin
        acc_d[63:32] = acc_q[63:32] + prod[31:0];
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    inc_d   = inc_q;
    if (cmd_i.rs_load) begin
      state_d = '0;
      inc_d   = {stream_q, 1'b1};
    end else if (cmd_i.add_inc) begin
      state_d = acc_q + inc_q;
    end else if (cmd_i.add_seed) begin
      state_d = state_q + seed_q;
    end
  end

  always_comb begin
    seed_d   = seed_q;
    stream_d = stream_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SEED:   seed_d   = cfg_data_i;
        CFG_STREAM: stream_d = cfg_data_i[62:0];
        default:    seed_d   = seed_q;
      endcase
    end
  end

  always_comb begin
    bound_d = cmd_i.load_item ? bound_i : bound_q;
    thr_d   = cmd_i.thr_load ? div_rem : thr_q;
    out_d   = out_q;
    if (cmd_i.emit) begin
      case (cmd_i.emit_sel)
        VAL_DRAW: out_d.value = draw_q;
        VAL_FRAC: out_d.value = {{FRAC_SHIFT{1'b0}}, draw_q[31:FRAC_SHIFT]};
        VAL_REM:  out_d.value = div_rem;
        default:  out_d.value = '0;
      endcase
      out_d.bad_bound = cmd_i.emit_bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= '0;
      inc_q    <= 64'd1;
      seed_q   <= '0;
      stream_q <= '0;
    end else begin
      state_q  <= state_d;
      inc_q    <= inc_d;
      seed_q   <= seed_d;
      stream_q <= stream_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    draw_q  <= draw_d;
    bound_q <= bound_d;
    thr_q   <= thr_d;
    out_q   <= out_d;
  end

  assign sts_o.bound_zero = (bound_q == '0);
  assign sts_o.draw_ok    = (draw_q >= thr_q);
  assign sts_o.div_done   = div_done;
  assign out_o            = out_q;

endmodule

// ===== design/pcg32_ctrl.sv =====
// sequencing state machine for reseed, draw, rejection and modulo steps
// depends on pcg32_pkg and pcg32_random_generator_unit_macros.svh
`include "pcg32_random_generator_unit_macros.svh"

module pcg32_ctrl
  import pcg32_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;
  logic   seed_done_q, seed_done_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (kind_q)
          KIND_RESEED:  state_d = S_RS_LOAD;
          KIND_BOUNDED: state_d = sts_i.bound_zero ? S_EMIT : S_THR;
          default:      state_d = S_MUL0;
        endcase
      end
      S_RS_LOAD: state_d = S_MUL0;
      S_MUL0:    state_d = S_MUL1;
      S_MUL1:    state_d = S_MUL2;
      S_MUL2:    state_d = S_ADD;
      S_ADD: begin
        case (kind_q)
          KIND_RESEED:  state_d = seed_done_q ? S_EMIT : S_RS_SEED;
          KIND_BOUNDED: state_d = sts_i.draw_ok ? S_MOD : S_MUL0;
          default:      state_d = S_EMIT;
        endcase
      end
      S_RS_SEED: state_d = S_MUL0;
      S_THR:     state_d = S_THR_WAIT;
      S_THR_WAIT: begin
        if (sts_i.div_done) state_d = S_MUL0;
      end
      S_MOD:     state_d = S_MOD_WAIT;
      S_MOD_WAIT: begin
        if (sts_i.div_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:     cmd_o.load_item = in_valid_i;
      S_RS_LOAD:  cmd_o.rs_load = 1'b1;
      S_MUL0:     cmd_o.mul_op = MUL_LO_LO;
      S_MUL1:     cmd_o.mul_op = MUL_LO_HI;
      S_MUL2:     cmd_o.mul_op = MUL_HI_LO;
      S_ADD:      cmd_o.add_inc = 1'b1;
      S_RS_SEED:  cmd_o.add_seed = 1'b1;
      S_THR:      cmd_o.div_start = 1'b1;
      S_THR_WAIT: cmd_o.thr_load = sts_i.div_done;
      S_MOD: begin
        cmd_o.div_start    = 1'b1;
        cmd_o.div_sel_draw = 1'b1;
      end
      S_EMIT: begin
        cmd_o.emit = out_free;
        case (kind_q)
          KIND_RAW:  cmd_o.emit_sel = VAL_DRAW;
          KIND_FRAC: cmd_o.emit_sel = VAL_FRAC;
          KIND_BOUNDED: begin
            cmd_o.emit_sel = sts_i.bound_zero ? VAL_ZERO : VAL_REM;
            cmd_o.emit_bad = sts_i.bound_zero;
          end
          default:   cmd_o.emit_sel = VAL_ZERO;
        endcase
      end
      default:    cmd_o = '0;
    endcase
  end

  always_comb begin
    kind_d      = accept ? kind_e'(kind_i) : kind_q;
    seed_done_d = seed_done_q;
    if (accept) begin
      seed_done_d = 1'b0;
    end else if (state_q == S_RS_SEED) begin
      seed_done_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= KIND_RESEED;
      seed_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      seed_done_q <= seed_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PCG32_ASSERT_NEXT(a_accept_to_decode, clk_i, rst_ni, accept, state_q == S_DECODE)
  `PCG32_ASSERT_NOW(a_emit_needs_room, clk_i, rst_ni, cmd_o.emit, out_free)
  `PCG32_ASSERT_NEXT(a_mul_sequence, clk_i, rst_ni, state_q == S_MUL0, state_q == S_MUL1)
  `PCG32_ASSERT_NOW(a_reseed_seeded, clk_i, rst_ni, (state_q == S_EMIT) && (kind_q == KIND_RESEED), seed_done_q)

endmodule

// ===== design/pcg32_random_generator_unit.sv =====
// pcg32 xsh-rr generator: one request word in, one result word out per request
// raw and fraction requests take one lcg step; a reseed loads state 0, steps, adds the seed
// and steps again; a bounded request runs the divider for the threshold, steps until a draw is
// accepted, then runs the divider for the modulo; a zero bound skips both; one request at a time
// reset (rst_ni, async low): state 0, increment 1, seed and stream registers 0, no word pending
// depends on pcg32_pkg, pcg32_ctrl, pcg32_datapath, pcg32_divider
module pcg32_random_generator_unit
  import pcg32_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_o,
  // configuration writes: index 0 seed, index 1 stream select
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // the controller steps through the lcg update as three partial products
  // on one shared 32x32 multiplier (low x low, low x high, high x low),
  // followed by the increment add; the draw is taken from the pre-step state.
  // bounded draws run the divider once for the rejection threshold and once
  // for the final modulo, and repeat the step while the draw is below the
  // threshold. the result word sits in an output register, so the next
  // request can be taken while a finished word waits on the result channel.
  cmd_t cmd;
  sts_t sts;

  pcg32_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (in_i.kind),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath holds the generator state, the config registers and the result word
  pcg32_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .bound_i     (in_i.bound),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_o       (out_o)
  );

endmodule
